// ===== rtl/srsec_pkg.sv =====
// shared types and constants of the stepper ramp sequencer
package srsec_pkg;

	// item operation codes
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// configuration register indexes
	localparam logic [1:0] CFG_ORIG_DIR  = 2'd0;
	localparam logic [1:0] CFG_PPC       = 2'd1;
	localparam logic [1:0] CFG_FINAL_MIN = 2'd2;
	localparam logic [1:0] CFG_OVER_MIN  = 2'd3;

	// configuration reset values
	localparam logic        RST_ORIG_DIR  = 1'b0;
	localparam logic [7:0]  RST_PPC       = 8'd25;
	localparam logic [15:0] RST_FINAL_MIN = 16'd25;
	localparam logic [15:0] RST_OVER_MIN  = 16'd4;

	// saturation limit of the pulse counter, the product and the corrected count
	localparam logic [15:0] CNT_MAX = 16'hFFFF;

	// one phase table entry
	typedef struct packed {
		logic [15:0] count;
		logic [15:0] period;
		logic [14:0] target;
	} entry_t;

	// table read address select
	typedef enum logic [2:0] {
		RS_ZERO       = 3'd0,
		RS_PHASE      = 3'd1,
		RS_PHASE_NEXT = 3'd2,
		RS_WALK_NEXT  = 3'd3,
		RS_PREV_LAST  = 3'd4
	} rsel_t;

	// controller to datapath commands
	typedef struct packed {
		logic  capture;
		logic  load_wr;
		logic  start_set;
		logic  halt;
		logic  lim;
		logic  finish;
		logic  tick_inc;
		logic  clr_wr;
		logic  walk_step;
		logic  walk_take;
		logic  mul;
		logic  apply;
		logic  recover;
		rsel_t rd_sel;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		op_t  op;
		logic run;
		logic limit;
		logic idx_ok;
		logic count_reached;
		logic at_last;
		logic entry_zero;
		logic walk_end;
		logic recover_ok;
	} sts_t;

endpackage

// ===== rtl/stepper_ramp_sequencer_encoder_comp_core.sv =====
// top level of the stepper ramp sequencer with encoder compensation
// each word goes through exec and then, by its operation, a table read, a walk over empty
// phases (one table read per cycle), the correction multiply and its apply, ending in the
// result strobe; load, no-op, limit and idle tick go from exec straight to the strobe
// busy stays high until the strobe cycle ends, so the next word goes in the cycle after it
// asynchronous reset clears the move state and loads config defaults; tables need no clearing
// the result strobe lasts one cycle and the receiver cannot stall it
module stepper_ramp_sequencer_encoder_comp_core #(
	parameter int PHASE_COUNT = 21
) (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [4:0]  phase_index,
	input  logic [15:0] pulse_count,
	input  logic [15:0] pulse_period,
	input  logic [14:0] encoder_target,
	input  logic        limit_hit,
	input  logic [15:0] encoder_count,
	// result channel
	output logic        result_valid,
	output logic        running,
	output logic [15:0] period_out,
	output logic [15:0] compare_out,
	output logic [4:0]  current_phase,
	output logic        move_finished,
	output logic        limit_stopped,
	output logic        direction_set,
	output logic        direction_out,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import srsec_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// config words are written at the accepting edge, always ready
	assign cfg_ready = 1'b1;

	// controller: one word at a time through exec, table reads, walk, multiply, apply
	srsec_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.result_valid (result_valid),
		.sts          (sts),
		.cmd          (cmd)
	);

	// datapath: tables, move registers, encoder fold and correction multiply
	srsec_dp #(
		.PHASE_COUNT (PHASE_COUNT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.operation      (operation),
		.phase_index    (phase_index),
		.pulse_count    (pulse_count),
		.pulse_period   (pulse_period),
		.encoder_target (encoder_target),
		.limit_hit      (limit_hit),
		.encoder_count  (encoder_count),
		.cfg_we         (cfg_valid & cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.running        (running),
		.period_out     (period_out),
		.compare_out    (compare_out),
		.current_phase  (current_phase),
		.move_finished  (move_finished),
		.limit_stopped  (limit_stopped),
		.direction_set  (direction_set),
		.direction_out  (direction_out)
	);

endmodule

// ===== rtl/srsec_ctrl.sv =====
// sequencing state machine of the stepper ramp sequencer
module srsec_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              result_valid,
	input  srsec_pkg::sts_t   sts,
	output srsec_pkg::cmd_t   cmd
);
	import srsec_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE      = 10'b00_0000_0001,
		S_EXEC      = 10'b00_0000_0010,
		S_START_RD  = 10'b00_0000_0100,
		S_TICK_RD   = 10'b00_0000_1000,
		S_WALK      = 10'b00_0001_0000,
		S_MUL       = 10'b00_0010_0000,
		S_APPLY     = 10'b00_0100_0000,
		S_FIN_MUL   = 10'b00_1000_0000,
		S_FIN_APPLY = 10'b01_0000_0000,
		S_RESULT    = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = (state_q == S_RESULT);

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = RS_PHASE;
		state_d    = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				case (sts.op)
					OP_LOAD: begin
						cmd.load_wr = sts.idx_ok;
						state_d     = S_RESULT;
					end
					OP_START: begin
						cmd.rd_sel = RS_ZERO;
						state_d    = S_START_RD;
					end
					OP_TICK: begin
						if (!sts.run) begin
							state_d = S_RESULT;
						end else if (sts.limit) begin
							cmd.halt = 1'b1;
							cmd.lim  = 1'b1;
							state_d  = S_RESULT;
						end else begin
							cmd.tick_inc = 1'b1;
							cmd.rd_sel   = RS_PHASE;
							state_d      = S_TICK_RD;
						end
					end
					default: state_d = S_RESULT;
				endcase
			end
			S_START_RD: begin
				cmd.start_set = 1'b1;
				state_d       = S_RESULT;
			end
			S_TICK_RD: begin
				if (!sts.count_reached) begin
					state_d = S_RESULT;
				end else begin
					cmd.clr_wr = 1'b1;
					if (sts.at_last) begin
						state_d = S_FIN_MUL;
					end else begin
						cmd.rd_sel = RS_PHASE_NEXT;
						state_d    = S_WALK;
					end
				end
			end
			S_WALK: begin
				if (sts.entry_zero) begin
					cmd.walk_step = 1'b1;
					if (sts.walk_end) begin
						cmd.halt   = 1'b1;
						cmd.finish = 1'b1;
						state_d    = S_RESULT;
					end else begin
						cmd.rd_sel = RS_WALK_NEXT;
					end
				end else begin
					cmd.walk_take = 1'b1;
					state_d       = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_APPLY;
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = S_RESULT;
			end
			S_FIN_MUL: begin
				cmd.mul    = 1'b1;
				cmd.rd_sel = RS_PREV_LAST;
				state_d    = S_FIN_APPLY;
			end
			S_FIN_APPLY: begin
				if (sts.recover_ok) begin
					cmd.recover = 1'b1;
				end else begin
					cmd.halt   = 1'b1;
					cmd.finish = 1'b1;
				end
				state_d = S_RESULT;
			end
			S_RESULT: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_result_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT) |=> (state_q == S_IDLE))
		else $error("result strobe not followed by idle");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_EXEC))
		else $error("accepted word not executed");

	a_walk_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (sts.op == OP_TICK && sts.run))
		else $error("phase walk outside a running tick");

endmodule

// ===== rtl/srsec_dp.sv =====
// phase tables, move state, encoder correction and configuration registers
module srsec_dp #(
	parameter int PHASE_COUNT = 21
) (
	input  logic              clk,
	input  logic              arst_n,
	input  srsec_pkg::cmd_t   cmd,
	output srsec_pkg::sts_t   sts,
	input  logic [1:0]        operation,
	input  logic [4:0]        phase_index,
	input  logic [15:0]       pulse_count,
	input  logic [15:0]       pulse_period,
	input  logic [14:0]       encoder_target,
	input  logic              limit_hit,
	input  logic [15:0]       encoder_count,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output logic              running,
	output logic [15:0]       period_out,
	output logic [15:0]       compare_out,
	output logic [4:0]        current_phase,
	output logic              move_finished,
	output logic              limit_stopped,
	output logic              direction_set,
	output logic              direction_out
);
	import srsec_pkg::*;

	localparam int           PW        = $clog2(PHASE_COUNT);
	localparam logic [PW:0]  PC_W      = (PW + 1)'(PHASE_COUNT);
	localparam logic [PW-1:0] LAST      = PW'(PHASE_COUNT - 1);
	localparam logic [PW-1:0] PREV_LAST = PW'(PHASE_COUNT - 2);
	localparam logic [5:0]   PC_IDX    = 6'(PHASE_COUNT);

	// phase tables
	entry_t        mem_q [PHASE_COUNT];
	entry_t        rdata_q;
	logic [PW-1:0] rd_addr;
	logic          wr_en;
	logic [PW-1:0] wr_addr;
	entry_t        wr_data;

	// move state
	logic          run_q, done_q, lim_q, dset_q;
	logic [PW-1:0] phase_q;
	logic [15:0]   counter_q;
	logic [15:0]   period_q;
	logic [PW:0]   walk_q;

	// configuration
	logic          orig_dir_q;
	logic [7:0]    ppc_q;
	logic [15:0]   final_min_q, over_min_q;

	// captured item and work registers
	logic [1:0]    op_q;
	logic [4:0]    idx_q;
	logic [15:0]   cnt_in_q, per_in_q, enc_q;
	logic [14:0]   tgt_in_q;
	logic          lim_in_q;
	logic [14:0]   prev_tgt_q, cur_tgt_q;
	logic [15:0]   cur_cnt_q, cur_per_q, prod_q;
	logic          lag_q, over_q;

	// correction arithmetic
	logic [15:0]   enc_fold, tgt16, abs_diff;
	logic          lag_d, over_d;
	logic [23:0]   product;
	logic [16:0]   sum17;
	logic [15:0]   new_cnt;
	logic [PW:0]   walk_inc;

	assign walk_inc = walk_q + 1'b1;

	always_comb begin
		case (cmd.rd_sel)
			RS_ZERO:       rd_addr = '0;
			RS_PHASE:      rd_addr = phase_q;
			RS_PHASE_NEXT: rd_addr = phase_q + 1'b1;
			RS_WALK_NEXT:  rd_addr = walk_inc[PW-1:0];
			RS_PREV_LAST:  rd_addr = PREV_LAST;
			default:       rd_addr = phase_q;
		endcase
	end

	// fold raw encoder to magnitude, then lag or overshoot against previous target
	always_comb begin
		enc_fold = enc_q[15] ? (~enc_q + 16'd1) : enc_q;
		tgt16    = {1'b0, prev_tgt_q};
		lag_d    = (tgt16 > enc_fold);
		over_d   = (enc_fold > tgt16);
		abs_diff = lag_d ? (tgt16 - enc_fold) : (enc_fold - tgt16);
		product  = abs_diff * ppc_q;
	end

	always_comb begin
		sum17 = {1'b0, cur_cnt_q} + {1'b0, prod_q};
		if (lag_q) begin
			new_cnt = sum17[16] ? CNT_MAX : sum17[15:0];
		end else if (over_q) begin
			if (prod_q > over_min_q && prod_q < cur_cnt_q) begin
				new_cnt = cur_cnt_q - prod_q;
			end else begin
				new_cnt = {1'b0, cur_cnt_q[15:1]};
			end
		end else begin
			new_cnt = cur_cnt_q;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = phase_q;
		wr_data = rdata_q;
		if (cmd.load_wr) begin
			wr_en   = 1'b1;
			wr_addr = idx_q[PW-1:0];
			wr_data = '{count: cnt_in_q, period: per_in_q, target: tgt_in_q};
		end else if (cmd.clr_wr) begin
			wr_en   = 1'b1;
			wr_addr = phase_q;
			wr_data = '{count: 16'd0, period: rdata_q.period, target: rdata_q.target};
		end else if (cmd.apply) begin
			wr_en   = 1'b1;
			wr_addr = walk_q[PW-1:0];
			wr_data = '{count: new_cnt, period: cur_per_q, target: cur_tgt_q};
		end else if (cmd.recover) begin
			wr_en   = 1'b1;
			wr_addr = LAST;
			wr_data = '{count: prod_q, period: cur_per_q, target: cur_tgt_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rdata_q <= mem_q[rd_addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= operation;
			idx_q    <= phase_index;
			cnt_in_q <= pulse_count;
			per_in_q <= pulse_period;
			tgt_in_q <= encoder_target;
			lim_in_q <= limit_hit;
			enc_q    <= encoder_count;
		end
		if (cmd.clr_wr) begin
			prev_tgt_q <= rdata_q.target;
			cur_per_q  <= rdata_q.period;
			cur_tgt_q  <= rdata_q.target;
			walk_q     <= {1'b0, phase_q} + 1'b1;
		end
		if (cmd.walk_step) begin
			prev_tgt_q <= rdata_q.target;
			walk_q     <= walk_inc;
		end
		if (cmd.walk_take) begin
			cur_cnt_q <= rdata_q.count;
			cur_per_q <= rdata_q.period;
			cur_tgt_q <= rdata_q.target;
		end
		if (cmd.mul) begin
			prod_q <= (|product[23:16]) ? CNT_MAX : product[15:0];
			lag_q  <= lag_d;
			over_q <= over_d;
		end
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			done_q      <= 1'b0;
			lim_q       <= 1'b0;
			dset_q      <= 1'b0;
			phase_q     <= '0;
			counter_q   <= '0;
			period_q    <= '0;
			orig_dir_q  <= RST_ORIG_DIR;
			ppc_q       <= RST_PPC;
			final_min_q <= RST_FINAL_MIN;
			over_min_q  <= RST_OVER_MIN;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ORIG_DIR:  orig_dir_q  <= cfg_data[0];
					CFG_PPC:       ppc_q       <= cfg_data[7:0];
					CFG_FINAL_MIN: final_min_q <= cfg_data;
					CFG_OVER_MIN:  over_min_q  <= cfg_data;
					default:       ppc_q       <= ppc_q;
				endcase
			end
			if (cmd.capture) begin
				lim_q  <= 1'b0;
				dset_q <= 1'b0;
			end
			if (cmd.start_set) begin
				run_q     <= 1'b1;
				done_q    <= 1'b0;
				phase_q   <= '0;
				counter_q <= '0;
				period_q  <= rdata_q.period;
			end
			if (cmd.halt) begin
				run_q     <= 1'b0;
				phase_q   <= '0;
				counter_q <= '0;
			end
			if (cmd.lim) begin
				lim_q <= 1'b1;
			end
			if (cmd.finish) begin
				done_q <= 1'b1;
			end
			if (cmd.tick_inc && counter_q != CNT_MAX) begin
				counter_q <= counter_q + 16'd1;
			end
			if (cmd.apply) begin
				phase_q   <= walk_q[PW-1:0];
				counter_q <= '0;
				period_q  <= cur_per_q;
			end
			if (cmd.recover) begin
				dset_q    <= 1'b1;
				phase_q   <= LAST;
				counter_q <= '0;
				period_q  <= rdata_q.period;
			end
		end
	end

	always_comb begin
		sts.op            = op_t'(op_q);
		sts.run           = run_q;
		sts.limit         = lim_in_q;
		sts.idx_ok        = ({1'b0, idx_q} < PC_IDX);
		sts.count_reached = (counter_q >= rdata_q.count);
		sts.at_last       = (phase_q == LAST);
		sts.entry_zero    = (rdata_q.count == 16'd0);
		sts.walk_end      = (walk_inc == PC_W);
		sts.recover_ok    = lag_q && (prod_q > final_min_q);
	end

	assign running       = run_q;
	assign period_out    = period_q;
	assign compare_out   = run_q ? {1'b0, period_q[15:1]} : 16'd0;
	assign current_phase = 5'(phase_q);
	assign move_finished = done_q;
	assign limit_stopped = lim_q;
	assign direction_set = dset_q;
	assign direction_out = dset_q & orig_dir_q;

	a_stopped_at_origin: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> (phase_q == '0 && counter_q == '0))
		else $error("stopped move left phase or pulse count");

	a_apply_restarts_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> (counter_q == '0 && run_q && phase_q != '0))
		else $error("phase advance did not restart the pulse count");

	a_limit_stop_halted: assert property (@(posedge clk) disable iff (!arst_n)
		lim_q |-> !run_q)
		else $error("limit stop flagged while the move still runs");

endmodule

// ===== tb/sv/stepper_ramp_sequencer_encoder_comp_core_test.sv =====
// self-checking testbench for the stepper ramp sequencer with encoder compensation
`timescale 1ns / 100ps

module stepper_ramp_sequencer_encoder_comp_core_test;
	import srsec_pkg::*;

	localparam int PHASES = 21;

	// kinds of entries in the stimulus queue
	typedef enum {ITEM_WORD, REG_WORD, HOLD_WORD, PACE_WORD} word_kind_t;

	// one queued word: an item, a register write, a drain marker or a pacing change
	typedef struct {
		word_kind_t  kind;
		op_t         op;
		logic [4:0]  idx;
		logic [15:0] count;
		logic [15:0] period;
		logic [14:0] target;
		logic        limit;
		logic [15:0] enc;
		logic [1:0]  reg_sel;
		logic [15:0] reg_val;
		int          pct;
	} word_t;

	// one status word as the block reports it
	typedef struct {
		logic        running;
		logic [15:0] period;
		logic [15:0] compare;
		logic [4:0]  phase;
		logic        finished;
		logic        limited;
		logic        dir_set;
		logic        dir_val;
	} status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// item channel, all driven to known values from time zero
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  operation = OP_NONE;
	logic [4:0]  phase_index = '0;
	logic [15:0] pulse_count = '0;
	logic [15:0] pulse_period = '0;
	logic [14:0] encoder_target = '0;
	logic        limit_hit = 1'b0;
	logic [15:0] encoder_count = '0;

	// status channel
	logic        result_valid;
	logic        running;
	logic [15:0] period_out;
	logic [15:0] compare_out;
	logic [4:0]  current_phase;
	logic        move_finished;
	logic        limit_stopped;
	logic        direction_set;
	logic        direction_out;

	// register write channel
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_ORIG_DIR;
	logic [15:0] cfg_data = '0;

	// stimulus waiting to go out and status words still owed by the block
	word_t   word_queue[$];
	status_t status_due[$];
	word_t   on_bus;
	int      gap_pct = 0;

	// shadow of the phase tables and move state
	logic [15:0] tbl_count[PHASES];
	logic [15:0] tbl_period[PHASES];
	logic [14:0] tbl_target[PHASES];
	logic [15:0] pulse_tally;
	logic [4:0]  phase_now;
	logic [15:0] period_now;
	logic        moving;
	logic        finished;

	// shadow of the settings
	logic        cf_orig_dir;
	logic [7:0]  cf_ppc;
	logic [15:0] cf_final_min;
	logic [15:0] cf_over_min;

	// bookkeeping
	int mismatch_count = 0;
	int items_queued = 0;
	int words_taken = 0;
	int statuses_seen = 0;
	int settings_written = 0;
	int moves_begun = 0;
	int moves_done = 0;
	int limit_halts = 0;
	int recoveries = 0;
	int phase_steps = 0;

	stepper_ramp_sequencer_encoder_comp_core #(
		.PHASE_COUNT(PHASES)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.phase_index    (phase_index),
		.pulse_count    (pulse_count),
		.pulse_period   (pulse_period),
		.encoder_target (encoder_target),
		.limit_hit      (limit_hit),
		.encoder_count  (encoder_count),
		.result_valid   (result_valid),
		.running        (running),
		.period_out     (period_out),
		.compare_out    (compare_out),
		.current_phase  (current_phase),
		.move_finished  (move_finished),
		.limit_stopped  (limit_stopped),
		.direction_set  (direction_set),
		.direction_out  (direction_out),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// profile predictor
	// ---------------------------------------------------------------

	function automatic int unsigned clamp16(input int unsigned v);
		return (v > 32'hFFFF) ? 32'hFFFF : v;
	endfunction

	// limit or finish drops the generator but keeps the last period
	function automatic void stop_move();
		moving      = 1'b0;
		pulse_tally = '0;
		phase_now   = '0;
	endfunction

	function automatic void reset_profile();
		for (int k = 0; k < PHASES; k++) begin
			tbl_count[k]  = '0;
			tbl_period[k] = '0;
			tbl_target[k] = '0;
		end
		pulse_tally  = '0;
		phase_now    = '0;
		period_now   = '0;
		moving       = 1'b0;
		finished     = 1'b0;
		cf_orig_dir  = RST_ORIG_DIR;
		cf_ppc       = RST_PPC;
		cf_final_min = RST_FINAL_MIN;
		cf_over_min  = RST_OVER_MIN;
	endfunction

	function automatic void write_setting(input logic [1:0] sel, input logic [15:0] v);
		case (sel)
		CFG_ORIG_DIR:  cf_orig_dir  = v[0];
		CFG_PPC:       cf_ppc       = v[7:0];
		CFG_FINAL_MIN: cf_final_min = v;
		CFG_OVER_MIN:  cf_over_min  = v;
		default: ;
		endcase
	endfunction

	// phase end: step on, skip empties, correct the next count from the encoder or stop
	function automatic void close_phase(input logic [15:0] enc_raw, output logic steer);
		int unsigned mag, tgt, diff, cnt;
		steer = 1'b0;
		phase_steps++;
		mag = enc_raw;
		tbl_count[phase_now] = '0;
		phase_now++;
		// counter below zero reads as its magnitude
		if (mag > 32767) mag = 65536 - mag;
		if (phase_now >= PHASES) begin
			tgt = tbl_target[PHASES-1];
			if (tgt > mag) begin
				diff = clamp16((tgt - mag) * cf_ppc);
				// final lag big enough: run the last phase again, one period back
				if (diff > cf_final_min) begin
					steer = 1'b1;
					phase_now = 5'(PHASES - 1);
					tbl_count[phase_now] = diff[15:0];
					pulse_tally = '0;
					period_now = tbl_period[PHASES-2];
					recoveries++;
					return;
				end
			end
			stop_move();
			finished = 1'b1;
			moves_done++;
			return;
		end
		while (phase_now < PHASES && tbl_count[phase_now] == 0) phase_now++;
		// walked off the end: done without an encoder check
		if (phase_now >= PHASES) begin
			stop_move();
			finished = 1'b1;
			moves_done++;
			return;
		end
		tgt = tbl_target[phase_now-1];
		cnt = tbl_count[phase_now];
		if (tgt > mag) begin
			diff = clamp16((tgt - mag) * cf_ppc);
			cnt = clamp16(cnt + diff);
		end else if (mag > tgt) begin
			diff = clamp16((mag - tgt) * cf_ppc);
			if (diff > cf_over_min && diff < cnt) cnt = cnt - diff;
			else cnt = cnt >> 1;
		end
		tbl_count[phase_now] = cnt[15:0];
		pulse_tally = '0;
		period_now = tbl_period[phase_now];
	endfunction

	// apply one accepted item and return the status it must produce
	function automatic status_t step_profile(input word_t w);
		status_t s;
		logic    halted;
		logic    steer;
		halted = 1'b0;
		steer  = 1'b0;
		case (w.op)
		OP_LOAD: begin
			// indexes past the table are dropped
			if (w.idx < PHASES) begin
				tbl_count[w.idx]  = w.count;
				tbl_period[w.idx] = w.period;
				tbl_target[w.idx] = w.target;
			end
		end
		OP_START: begin
			phase_now   = '0;
			pulse_tally = '0;
			moving      = 1'b1;
			finished    = 1'b0;
			period_now  = tbl_period[0];
			moves_begun++;
		end
		OP_TICK: begin
			// ticks on a stopped generator change nothing
			if (moving) begin
				if (w.limit) begin
					stop_move();
					halted = 1'b1;
					limit_halts++;
				end else begin
					if (pulse_tally != 16'hFFFF) pulse_tally++;
					if (pulse_tally >= tbl_count[phase_now]) close_phase(w.enc, steer);
				end
			end
		end
		default: ;
		endcase
		s.running  = moving;
		s.period   = period_now;
		s.compare  = moving ? (period_now >> 1) : '0;
		s.phase    = phase_now;
		s.finished = finished;
		s.limited  = halted;
		s.dir_set  = steer;
		s.dir_val  = steer ? cf_orig_dir : 1'b0;
		return s;
	endfunction

	task automatic flag_mismatch(input string why);
		mismatch_count++;
		// keep the log bounded on a badly broken build
		if (mismatch_count <= 100) $display("%0t mismatch: %s", $time, why);
	endtask

	// ---------------------------------------------------------------
	// stimulus builders
	// ---------------------------------------------------------------

	// unused fields carry random bits so every input bit toggles
	function automatic word_t noise_word();
		word_t w;
		w.kind    = ITEM_WORD;
		w.op      = OP_NONE;
		w.idx     = 5'($urandom);
		w.count   = 16'($urandom);
		w.period  = 16'($urandom);
		w.target  = 15'($urandom);
		w.limit   = 1'($urandom);
		w.enc     = 16'($urandom);
		w.reg_sel = CFG_ORIG_DIR;
		w.reg_val = '0;
		w.pct     = 0;
		return w;
	endfunction

	task automatic add_load(input logic [4:0] i, input logic [15:0] c, input logic [15:0] p,
			input logic [14:0] t);
		word_t w;
		w = noise_word();
		w.op = OP_LOAD;
		w.idx = i;
		w.count = c;
		w.period = p;
		w.target = t;
		word_queue.push_back(w);
		items_queued++;
	endtask

	task automatic add_op(input op_t o);
		word_t w;
		w = noise_word();
		w.op = o;
		word_queue.push_back(w);
		items_queued++;
	endtask

	task automatic add_tick(input logic l, input logic [15:0] e);
		word_t w;
		w = noise_word();
		w.op = OP_TICK;
		w.limit = l;
		w.enc = e;
		word_queue.push_back(w);
		items_queued++;
	endtask

	task automatic add_setting(input logic [1:0] sel, input logic [15:0] v);
		word_t w;
		w = noise_word();
		w.kind = REG_WORD;
		w.reg_sel = sel;
		w.reg_val = v;
		word_queue.push_back(w);
	endtask

	task automatic add_marker(input word_kind_t k, input int pct);
		word_t w;
		w = noise_word();
		w.kind = k;
		w.pct = pct;
		word_queue.push_back(w);
	endtask

	// mostly in-table indexes, now and then one the block must drop
	function automatic logic [4:0] pick_index();
		return ($urandom_range(0, 14) == 0) ? 5'($urandom_range(21, 31))
			: 5'($urandom_range(0, PHASES - 1));
	endfunction

	// short phases keep moves flowing; rare huge ones exercise the top bits
	function automatic logic [15:0] pick_count();
		int r;
		r = $urandom_range(0, 39);
		if (r == 0) return 16'($urandom);
		if (r < 4) return 16'($urandom_range(4, 12));
		return 16'($urandom_range(0, 3));
	endfunction

	// targets cluster in a narrow band so corrections stay small
	function automatic logic [14:0] pick_target();
		return ($urandom_range(0, 19) == 0) ? 15'($urandom) : 15'(100 + $urandom_range(0, 3));
	endfunction

	// encoder near the band, sometimes counted the other way round, rarely wild
	function automatic logic [15:0] pick_encoder();
		int r;
		int unsigned mag;
		r = $urandom_range(0, 15);
		mag = $urandom_range(98, 106);
		if (r == 0) return 16'($urandom);
		if (r < 3) return 16'(32'h10000 - mag);
		return 16'(mag);
	endfunction

	function automatic int pick_pace();
		case ($urandom_range(0, 2))
		0: return 0;
		1: return 20;
		default: return 49;
		endcase
	endfunction

	// one move: refresh a few phases, start, then ticks with the odd restart, load or limit
	task automatic add_move();
		int n_reload;
		int n_tick;
		n_reload = $urandom_range(2, 8);
		repeat (n_reload) add_load(pick_index(), pick_count(), 16'($urandom), pick_target());
		if ($urandom_range(0, 9) == 0) add_op(OP_NONE);
		add_op(OP_START);
		n_tick = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(3, 30);
		repeat (n_tick) begin
			case ($urandom_range(0, 49))
			0: add_op(OP_START);
			1: add_load(pick_index(), pick_count(), 16'($urandom), pick_target());
			2: add_op(OP_NONE);
			default: add_tick($urandom_range(0, 39) == 0, pick_encoder());
			endcase
		end
		// a trailing tick that may find the generator stopped
		if ($urandom_range(0, 3) == 0) add_tick(1'($urandom), pick_encoder());
	endtask

	// ---------------------------------------------------------------
	// driver: presents queued words, predicts on every accepted item
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		logic hold_item;
		logic hold_reg;
		logic settled;
		if (!arst_n) begin
			start     <= 1'b0;
			cfg_valid <= 1'b0;
			reset_profile();
		end else begin
			hold_item = start;
			hold_reg  = cfg_valid;
			// item taken at this edge
			if (start && !busy) begin
				status_due.push_back(step_profile(on_bus));
				words_taken++;
				hold_item = 1'b0;
			end
			// register write taken at this edge
			if (cfg_valid && cfg_ready) begin
				write_setting(cfg_index, cfg_data);
				settings_written++;
				hold_reg = 1'b0;
			end
			// nothing left in flight: no strobe now and no status still owed
			settled = !result_valid && status_due.size() == 0;
			if (!hold_item && !hold_reg) begin
				while (word_queue.size() != 0 && word_queue[0].kind == PACE_WORD) begin
					gap_pct = word_queue[0].pct;
					void'(word_queue.pop_front());
				end
				if (word_queue.size() != 0) begin
					case (word_queue[0].kind)
					ITEM_WORD: begin
						// random sender gaps at the current pace
						if ($urandom_range(0, 99) >= gap_pct) begin
							on_bus = word_queue.pop_front();
							hold_item = 1'b1;
							operation      <= on_bus.op;
							phase_index    <= on_bus.idx;
							pulse_count    <= on_bus.count;
							pulse_period   <= on_bus.period;
							encoder_target <= on_bus.target;
							limit_hit      <= on_bus.limit;
							encoder_count  <= on_bus.enc;
						end
					end
					REG_WORD: begin
						// settings change only with the block idle
						if (settled) begin
							cfg_index <= word_queue[0].reg_sel;
							cfg_data  <= word_queue[0].reg_val;
							hold_reg = 1'b1;
							void'(word_queue.pop_front());
						end
					end
					HOLD_WORD: begin
						// sender waits out every owed status
						if (settled) void'(word_queue.pop_front());
					end
					default: ;
					endcase
				end
			end
			start     <= hold_item;
			cfg_valid <= hold_reg;
		end
	end

	// ---------------------------------------------------------------
	// monitor: every strobe is checked against the oldest prediction
	// the receiver side has no stall, so status words are taken as they come
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		status_t want;
		string   bad;
		if (arst_n && result_valid) begin
			statuses_seen++;
			if (status_due.size() == 0) begin
				flag_mismatch($sformatf("status word %0d arrived with none outstanding",
					statuses_seen));
			end else begin
				want = status_due.pop_front();
				bad = "";
				if (running !== want.running) bad = {bad, " running"};
				if (period_out !== want.period) bad = {bad, " period_out"};
				if (compare_out !== want.compare) bad = {bad, " compare_out"};
				if (current_phase !== want.phase) bad = {bad, " current_phase"};
				if (move_finished !== want.finished) bad = {bad, " move_finished"};
				if (limit_stopped !== want.limited) bad = {bad, " limit_stopped"};
				if (direction_set !== want.dir_set) bad = {bad, " direction_set"};
				if (direction_out !== want.dir_val) bad = {bad, " direction_out"};
				if (bad != "")
					flag_mismatch($sformatf(
						"status word %0d wrong in%s: exp %0b %h %h %0d %0b %0b %0b %0b, got %b %h %h %0d %b %b %b %b",
						statuses_seen, bad, want.running, want.period, want.compare,
						want.phase, want.finished, want.limited, want.dir_set, want.dir_val,
						running, period_out, compare_out, current_phase, move_finished,
						limit_stopped, direction_set, direction_out));
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus plan, reset and end of run
	// ---------------------------------------------------------------
	initial begin
		int goal;
		int k;

		// directed opening at reset settings, no sender gaps
		add_marker(PACE_WORD, 0);
		add_op(OP_NONE);
		// tick with the limit on while stopped: ignored
		add_tick(1'b1, 16'hFFFF);
		// fill the whole table: all counts empty, extreme periods and targets at the ends
		for (k = 0; k < PHASES; k++)
			add_load(5'(k), 16'd0,
				(k == 0) ? 16'hFFFF : (k == PHASES - 2) ? 16'd0 : 16'($urandom),
				(k == PHASES - 1) ? 15'h7FFF : (k == PHASES - 2) ? 15'd0 : pick_target());
		// load past the table with every field at its top: dropped
		add_load(5'd31, 16'hFFFF, 16'hFFFF, 15'h7FFF);
		// empty first phase still takes a tick, then the skip runs off the end
		add_op(OP_START);
		add_tick(1'b0, 16'h0000);
		// only the last phase holds pulses
		add_load(5'(PHASES - 1), 16'd1, 16'h04D2, 15'h7FFF);
		add_op(OP_START);
		// encoder at the fold point: overshoot saturates, too big to subtract, count halves
		add_tick(1'b0, 16'h8000);
		// folded encoder of one against a full target: saturated lag, last phase reruns
		add_tick(1'b0, 16'hFFFF);
		// restart while running, then the limit stops it
		add_op(OP_START);
		add_tick(1'b1, 16'h0000);

		// random moves under five settings, including both extremes
		for (int ph = 0; ph < 5; ph++) begin
			add_marker(HOLD_WORD, 0);
			case (ph)
			1: begin
				add_setting(CFG_ORIG_DIR, 16'd1);
				add_setting(CFG_PPC, 16'd1);
				add_setting(CFG_FINAL_MIN, 16'd0);
				add_setting(CFG_OVER_MIN, 16'd0);
				add_marker(PACE_WORD, 49);
			end
			2: begin
				add_setting(CFG_ORIG_DIR, 16'd0);
				add_setting(CFG_PPC, 16'd255);
				add_setting(CFG_FINAL_MIN, 16'hFFFF);
				add_setting(CFG_OVER_MIN, 16'hFFFF);
				add_marker(PACE_WORD, 20);
			end
			3: begin
				add_setting(CFG_ORIG_DIR, 16'd1);
				add_setting(CFG_PPC, 16'd3);
				add_setting(CFG_FINAL_MIN, 16'd5);
				add_setting(CFG_OVER_MIN, 16'd2);
				add_marker(PACE_WORD, 0);
			end
			4: begin
				add_setting(CFG_ORIG_DIR, 16'($urandom_range(0, 1)));
				add_setting(CFG_PPC, 16'($urandom_range(1, 255)));
				add_setting(CFG_FINAL_MIN, 16'($urandom_range(0, 300)));
				add_setting(CFG_OVER_MIN, 16'($urandom_range(0, 40)));
				add_marker(PACE_WORD, 49);
			end
			default: add_marker(PACE_WORD, 0);
			endcase
			goal = items_queued + 110;
			while (items_queued < goal) begin
				add_move();
				if ($urandom_range(0, 5) == 0) add_marker(HOLD_WORD, 0);
				if ($urandom_range(0, 7) == 0) add_marker(PACE_WORD, pick_pace());
			end
		end

		// single reset at the start
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// all stimulus out, then the owed status words, then a quiet tail
		while (word_queue.size() != 0 || start || cfg_valid) @(posedge clk);
		for (k = 0; k < 200 && status_due.size() != 0; k++) @(posedge clk);
		repeat (40) @(posedge clk);
		while (status_due.size() != 0) begin
			flag_mismatch("status word never arrived");
			void'(status_due.pop_front());
		end

		$display("covered %0d items and %0d register writes, sender idle 0/20/49 percent",
			words_taken, settings_written);
		$display("moves %0d started, %0d finished, %0d limit stops, %0d final reruns, %0d phase ends",
			moves_begun, moves_done, limit_halts, recoveries, phase_steps);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/srsec_pkg.sv
rtl/srsec_ctrl.sv
rtl/srsec_dp.sv
rtl/stepper_ramp_sequencer_encoder_comp_core.sv
tb/sv/stepper_ramp_sequencer_encoder_comp_core_test.sv
